// ===== hdl/lfu_cache_table_core_macros.svh =====
// assertion macros for the lfu cache table
// used by the top level only, no other dependencies
`ifndef LFU_CACHE_TABLE_CORE_MACROS_SVH
`define LFU_CACHE_TABLE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define LFU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lfu cache assertion failed");
`define LFU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfu cache assertion failed");
`define LFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfu cache assertion failed");
`else
`define LFU_ASSERT(lbl, clk, rst_n, prop)
`define LFU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LFU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/lfu_pkg.sv =====
// types and constants shared by the lfu cache table
// no dependencies
package lfu_pkg;

  localparam int unsigned KeyW       = 32;
  localparam int unsigned ValW       = 32;
  localparam int unsigned CountW     = 32;
  localparam int unsigned StampW     = 64;
  localparam int unsigned CfgW       = 5;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned CapacityDef = 16;

  localparam logic [CfgW-1:0] CapacityReset = 5'd16;
  localparam logic [ValW-1:0] MissValue     = 32'hFFFF_FFFF;
  localparam logic [ValW-1:0] PutValue      = 32'h0000_0000;
  localparam logic [CountW-1:0] CountFirst  = 32'd1;

  // operation codes
  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  // register index taken from paddr bit 2
  localparam logic RegCapacity = 1'b0;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ValW-1:0]   value;
    logic [CountW-1:0] count;
    logic [StampW-1:0] stamp;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_RESP   = 4'b1000
  } state_e;

  function automatic logic [CountW-1:0] count_inc(input logic [CountW-1:0] c);
    count_inc = (c == '1) ? c : c + CountW'(1);
  endfunction

endpackage

// ===== hdl/lfu_cache_table_core.sv =====
// lfu cache table: key-value store with least-frequently-used replacement and
// least-recent-touch tiebreak, one get or put per item, one result per item.
// an item walks all CAPACITY slots of the entry memory one per cycle through a
// single registered read port and one shared match/victim compare unit, then
// does any write-back to the matched, free or victim slot in ST_DECIDE and
// loads the result register in ST_RESP before it returns to ST_IDLE, where the
// next item is taken; no new item is taken while one is in flight, and a
// result still waiting in the output register holds the item back.
// depends on lfu_pkg and lfu_cache_table_core_macros.svh
`include "lfu_cache_table_core_macros.svh"

module lfu_cache_table_core #(
  parameter int unsigned CAPACITY = lfu_pkg::CapacityDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // item input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               op_i,
  input  logic signed [lfu_pkg::KeyW-1:0]    key_i,
  input  logic signed [lfu_pkg::ValW-1:0]    value_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               hit_o,
  output logic signed [lfu_pkg::ValW-1:0]    read_value_o,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lfu_pkg::ApbAddrW-1:0]       paddr,
  input  logic [lfu_pkg::ApbDataW-1:0]       pwdata,
  output logic [lfu_pkg::ApbDataW-1:0]       prdata,
  output logic                               pready
);
  import lfu_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CapW = (CntW > CfgW) ? CntW : CfgW;

  // entry memory, contents undefined until written, guarded by valid bits
  entry_t mem [CAPACITY];
  entry_t rdata_q;
  logic [IdxW-1:0] raddr;
  logic            mem_we;
  logic [IdxW-1:0] waddr;
  entry_t          wentry;

  // control state
  state_e               state_q, state_d;
  logic [CntW-1:0]      scan_idx_q, scan_idx_d;
  logic                 proc_vld_q, proc_vld_d;
  logic [IdxW-1:0]      proc_idx_q, proc_idx_d;
  logic [CAPACITY-1:0]  valid_q, valid_d;
  logic [CntW-1:0]      occ_q, occ_d;
  logic [StampW-1:0]    touch_q, touch_d;
  logic [CfgW-1:0]      capacity_q, capacity_d;
  logic                 out_valid_q, out_valid_d;
  logic                 match_found_q, match_found_d;
  logic                 free_found_q, free_found_d;
  logic                 vict_found_q, vict_found_d;

  // payload state
  logic                 req_op_q, req_op_d;
  logic [KeyW-1:0]      req_key_q, req_key_d;
  logic [ValW-1:0]      req_val_q, req_val_d;
  logic [IdxW-1:0]      match_idx_q, match_idx_d;
  logic [ValW-1:0]      match_val_q, match_val_d;
  logic [CountW-1:0]    match_cnt_q, match_cnt_d;
  logic [IdxW-1:0]      free_idx_q, free_idx_d;
  logic [IdxW-1:0]      vict_idx_q, vict_idx_d;
  logic [CountW-1:0]    vict_cnt_q, vict_cnt_d;
  logic [StampW-1:0]    vict_stamp_q, vict_stamp_d;
  logic                 pend_hit_q, pend_hit_d;
  logic [ValW-1:0]      pend_val_q, pend_val_d;
  logic                 hit_q, hit_d;
  logic [ValW-1:0]      rval_q, rval_d;

  logic [CapW-1:0]      cap_act;
  logic                 cfg_wr;
  logic                 proc_valid_bit;
  logic                 scan_last;

  assign cap_act = (CapW'(capacity_q) > CapW'(CAPACITY)) ? CapW'(CAPACITY) : CapW'(capacity_q);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == RegCapacity) ? ApbDataW'(capacity_q) : '0;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = rval_q;

  assign raddr          = (scan_idx_q < CntW'(CAPACITY)) ? scan_idx_q[IdxW-1:0] : '0;
  assign proc_valid_bit = valid_q[proc_idx_q];
  assign scan_last      = (scan_idx_q == CntW'(CAPACITY));

  always_comb begin
    state_d       = state_q;
    scan_idx_d    = scan_idx_q;
    proc_vld_d    = 1'b0;
    proc_idx_d    = proc_idx_q;
    valid_d       = valid_q;
    occ_d         = occ_q;
    touch_d       = touch_q;
    capacity_d    = capacity_q;
    out_valid_d   = out_valid_q;
    match_found_d = match_found_q;
    free_found_d  = free_found_q;
    vict_found_d  = vict_found_q;
    req_op_d      = req_op_q;
    req_key_d     = req_key_q;
    req_val_d     = req_val_q;
    match_idx_d   = match_idx_q;
    match_val_d   = match_val_q;
    match_cnt_d   = match_cnt_q;
    free_idx_d    = free_idx_q;
    vict_idx_d    = vict_idx_q;
    vict_cnt_d    = vict_cnt_q;
    vict_stamp_d  = vict_stamp_q;
    pend_hit_d    = pend_hit_q;
    pend_val_d    = pend_val_q;
    hit_d         = hit_q;
    rval_d        = rval_q;
    mem_we        = 1'b0;
    waddr         = match_idx_q;
    wentry        = '{key: req_key_q, value: req_val_q, count: CountFirst, stamp: touch_q};

    if (cfg_wr && (paddr[2] == RegCapacity)) begin
      capacity_d = pwdata[CfgW-1:0];
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_op_d      = op_i;
          req_key_d     = key_i;
          req_val_d     = value_i;
          scan_idx_d    = '0;
          match_found_d = 1'b0;
          free_found_d  = 1'b0;
          vict_found_d  = 1'b0;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue read of one slot while comparing the slot read last cycle
        if (!scan_last) begin
          proc_vld_d = 1'b1;
          proc_idx_d = raddr;
          scan_idx_d = scan_idx_q + CntW'(1);
        end else begin
          state_d = ST_DECIDE;
        end
        if (proc_vld_q) begin
          if (!proc_valid_bit) begin
            if (!free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = proc_idx_q;
            end
          end else begin
            if (!match_found_q && (rdata_q.key == req_key_q)) begin
              match_found_d = 1'b1;
              match_idx_d   = proc_idx_q;
              match_val_d   = rdata_q.value;
              match_cnt_d   = rdata_q.count;
            end
            // lowest count first, then oldest touch, first slot wins ties
            if (!vict_found_q ||
                ({rdata_q.count, rdata_q.stamp} < {vict_cnt_q, vict_stamp_q})) begin
              vict_found_d = 1'b1;
              vict_idx_d   = proc_idx_q;
              vict_cnt_d   = rdata_q.count;
              vict_stamp_d = rdata_q.stamp;
            end
          end
        end
      end
      ST_DECIDE: begin
        state_d = ST_RESP;
        if (req_op_q == OpGet) begin
          pend_hit_d = match_found_q;
          pend_val_d = match_found_q ? match_val_q : MissValue;
          if (match_found_q) begin
            mem_we  = 1'b1;
            waddr   = match_idx_q;
            wentry  = '{key: req_key_q, value: match_val_q,
                        count: count_inc(match_cnt_q), stamp: touch_q};
            touch_d = touch_q + StampW'(1);
          end
        end else begin
          pend_hit_d = 1'b0;
          pend_val_d = PutValue;
          if (cap_act != '0) begin
            mem_we  = 1'b1;
            touch_d = touch_q + StampW'(1);
            if (match_found_q) begin
              waddr  = match_idx_q;
              wentry = '{key: req_key_q, value: req_val_q,
                         count: count_inc(match_cnt_q), stamp: touch_q};
            end else begin
              if (CapW'(occ_q) >= cap_act) begin
                waddr = vict_idx_q;
              end else begin
                waddr = free_idx_q;
                occ_d = occ_q + CntW'(1);
              end
              valid_d[waddr] = 1'b1;
              wentry = '{key: req_key_q, value: req_val_q, count: CountFirst, stamp: touch_q};
            end
          end
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          hit_d       = pend_hit_q;
          rval_d      = pend_val_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      scan_idx_q    <= '0;
      proc_vld_q    <= 1'b0;
      proc_idx_q    <= '0;
      valid_q       <= '0;
      occ_q         <= '0;
      touch_q       <= '0;
      capacity_q    <= CapacityReset;
      out_valid_q   <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      vict_found_q  <= 1'b0;
    end else begin
      state_q       <= state_d;
      scan_idx_q    <= scan_idx_d;
      proc_vld_q    <= proc_vld_d;
      proc_idx_q    <= proc_idx_d;
      valid_q       <= valid_d;
      occ_q         <= occ_d;
      touch_q       <= touch_d;
      capacity_q    <= capacity_d;
      out_valid_q   <= out_valid_d;
      match_found_q <= match_found_d;
      free_found_q  <= free_found_d;
      vict_found_q  <= vict_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_op_q     <= req_op_d;
    req_key_q    <= req_key_d;
    req_val_q    <= req_val_d;
    match_idx_q  <= match_idx_d;
    match_val_q  <= match_val_d;
    match_cnt_q  <= match_cnt_d;
    free_idx_q   <= free_idx_d;
    vict_idx_q   <= vict_idx_d;
    vict_cnt_q   <= vict_cnt_d;
    vict_stamp_q <= vict_stamp_d;
    pend_hit_q   <= pend_hit_d;
    pend_val_q   <= pend_val_d;
    hit_q        <= hit_d;
    rval_q       <= rval_d;
  end

  // single write port, single registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wentry;
    end
    rdata_q <= mem[raddr];
  end

  `LFU_ASSERT(a_occ_matches_valid, clk_i, rst_ni, $countones(valid_q) == int'(occ_q))
  `LFU_ASSERT(a_occ_bounded, clk_i, rst_ni, occ_q <= CntW'(CAPACITY))
  `LFU_ASSERT_NEXT(a_touch_only_on_decide, clk_i, rst_ni, state_q != ST_DECIDE, $stable(touch_q))
  `LFU_ASSERT_IMPL(a_result_from_resp, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_RESP)

endmodule
